@@ rtl/lvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lvc_pkg
// Shared constants, types and helpers for the leader vector clustering block.
// ----------------------------------------------------------------------------
package lvc_pkg;

    localparam int MAX_CENTERS = 64;
    localparam int VEC_LEN     = 1024;

    localparam int ELEM_W    = 8;
    localparam int ACC_W     = 27;
    localparam int THR_W     = 26;
    localparam int DIST_W    = 26;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;

    localparam int CIDX_W      = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CNT_W       = $clog2(MAX_CENTERS + 1);
    localparam int POS_W       = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
    localparam int POSC_W      = $clog2(VEC_LEN + 1);
    localparam int STORE_DEPTH = MAX_CENTERS * VEC_LEN;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(25000000);
    localparam logic [ACC_W-1:0] DIST_MAX  = ACC_W'((64'd1 << DIST_W) - 64'd1);

    // request type codes on the input channel
    localparam logic REQ_FEATURE = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    // control from the sequencer to the accumulator unit
    typedef struct packed {
        logic              start;
        logic              issue;
        logic [CIDX_W-1:0] idx;
        logic              zero_acc;
        logic              add_en;
        logic [ELEM_W-1:0] elem;
    } t_acc_ctl;

    typedef struct packed {
        logic [CIDX_W-1:0] idx;
        logic [ACC_W-1:0]  dist_sq;
    } t_acc_best;

    function automatic logic [STORE_AW-1:0] store_addr(
        input logic [CIDX_W-1:0] center,
        input logic [POS_W-1:0]  pos
    );
        return STORE_AW'(center) * STORE_AW'(VEC_LEN) + STORE_AW'(pos);
    endfunction

endpackage

@@ rtl/leader_vector_clustering.sv @@
// ----------------------------------------------------------------------------
// leader_vector_clustering
// Leader clustering of byte vectors under squared L2 distance.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one transaction per vector
// element, or a clear request when i_req_type is 1. Output channel
// (o_out_valid / i_out_stall) carries one transaction per vector, issued on
// the element marked i_last_element. The threshold is written through
// i_cfg_we / i_cfg_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this. Each element is compared
// against the held centers one per cycle: the accumulator RAM does a
// read-modify-write per center. With centers held, an element stalls the
// input through the scan and drain states; a last element then has its
// result registered in the result state; clear requests do not stall.
// The output register decouples the sides: the next element is accepted
// while a result waits. A new result waits in place while the previous one
// is still stalled.
// Reset empties the center table, restarts the vector and loads the
// threshold with 25000000. The center RAM itself is not cleared.
// ----------------------------------------------------------------------------
module leader_vector_clustering (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lvc_pkg::THR_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [lvc_pkg::ELEM_W-1:0]    i_element,
    input  logic                          i_last_element,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lvc_pkg::IDX_OUT_W-1:0] o_cluster_index,
    output logic                          o_new_center,
    output logic                          o_table_full,
    output logic [lvc_pkg::DIST_W-1:0]    o_min_distance_sq,
    output logic [lvc_pkg::CNT_OUT_W-1:0] o_center_count
);
    import lvc_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_held;
    logic [POSC_W-1:0] r_pos;
    logic [THR_W-1:0]  r_thr;
    logic [ELEM_W-1:0] r_elem;
    logic              r_zero;
    logic              r_add;
    logic              r_last;
    logic [POS_W-1:0]  r_pos_rd;
    logic [CIDX_W-1:0] r_scan;

    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic                 r_out_new;
    logic                 r_out_full;
    logic [DIST_W-1:0]    r_out_dist;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    logic                accept;
    logic                feat_accept;
    logic                pos_in_range;
    logic                cm_we;
    logic [STORE_AW-1:0] cm_waddr;
    logic                cm_re;
    logic [STORE_AW-1:0] cm_raddr;
    logic [ELEM_W-1:0]   cm_rdata;
    t_acc_ctl            acc_ctl;
    t_acc_best           best;

    logic              res_found;
    logic              res_join;
    logic              res_room;
    logic [CIDX_W-1:0] res_idx;
    logic [CNT_W-1:0]  res_held;
    logic [DIST_W-1:0] res_dist;
    logic              load_out;

    assign o_in_stall   = (r_state != ST_IDLE);
    assign accept       = i_in_valid && !o_in_stall;
    assign feat_accept  = accept && (i_req_type == REQ_FEATURE);
    assign pos_in_range = (r_pos < POSC_W'(VEC_LEN));

    // speculative write of the element into the next free center slot
    assign cm_we    = feat_accept && pos_in_range && (r_held < CNT_W'(MAX_CENTERS));
    assign cm_waddr = store_addr(r_held[CIDX_W-1:0], r_pos[POS_W-1:0]);
    assign cm_re    = (r_state == ST_SCAN);
    assign cm_raddr = store_addr(r_scan, r_pos_rd);

    lvc_center_mem u_center_mem (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (i_element),
        .i_re    (cm_re),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    always_comb begin
        acc_ctl.start    = feat_accept;
        acc_ctl.issue    = (r_state == ST_SCAN);
        acc_ctl.idx      = r_scan;
        acc_ctl.zero_acc = r_zero;
        acc_ctl.add_en   = r_add;
        acc_ctl.elem     = r_elem;
    end

    lvc_acc_unit u_acc_unit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (acc_ctl),
        .i_center_byte (cm_rdata),
        .o_best        (best)
    );

    // end-of-vector decision
    always_comb begin
        res_found = (r_held != '0);
        res_join  = res_found && (best.dist_sq < ACC_W'(r_thr));
        res_room  = (r_held < CNT_W'(MAX_CENTERS));
        res_held  = r_held;
        if (res_join) begin
            res_idx = best.idx;
        end else if (res_room) begin
            res_idx  = r_held[CIDX_W-1:0];
            res_held = r_held + CNT_W'(1);
        end else begin
            res_idx = best.idx;
        end
        if (!res_found || best.dist_sq > DIST_MAX) begin
            res_dist = '1;
        end else begin
            res_dist = best.dist_sq[DIST_W-1:0];
        end
    end

    assign load_out = (r_state == ST_RESULT) && !(r_out_valid && i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (feat_accept) begin
                    if (r_held != '0) begin
                        n_state = ST_SCAN;
                    end else if (i_last_element) begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (r_scan == CIDX_W'(r_held - CNT_W'(1))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = r_last ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pos  <= '0;
            r_thr  <= THR_RESET;
            r_scan <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (accept && (i_req_type == REQ_CLEAR)) begin
                r_held <= '0;
                r_pos  <= '0;
            end else if (feat_accept) begin
                r_scan <= '0;
                if (pos_in_range) begin
                    r_pos <= r_pos + POSC_W'(1);
                end
            end else if (r_state == ST_SCAN) begin
                r_scan <= r_scan + CIDX_W'(1);
            end else if (load_out) begin
                r_held <= res_held;
                r_pos  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (feat_accept) begin
            r_elem   <= i_element;
            r_last   <= i_last_element;
            r_zero   <= (r_pos == '0);
            r_add    <= pos_in_range;
            r_pos_rd <= r_pos[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_idx  <= IDX_OUT_W'(res_idx);
            r_out_new  <= !res_join && res_room;
            r_out_full <= !res_join && !res_room;
            r_out_dist <= res_dist;
            r_out_cnt  <= CNT_OUT_W'(res_held);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cluster_index   = r_out_idx;
    assign o_new_center      = r_out_new;
    assign o_table_full      = r_out_full;
    assign o_min_distance_sq = r_out_dist;
    assign o_center_count    = r_out_cnt;

endmodule

@@ rtl/lvc_center_mem.sv @@
// ----------------------------------------------------------------------------
// lvc_center_mem
// Center vector storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lvc_center_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [lvc_pkg::STORE_AW-1:0]  i_waddr,
    input  logic [lvc_pkg::ELEM_W-1:0]    i_wdata,
    input  logic                          i_re,
    input  logic [lvc_pkg::STORE_AW-1:0]  i_raddr,
    output logic [lvc_pkg::ELEM_W-1:0]    o_rdata
);
    import lvc_pkg::*;

    logic [ELEM_W-1:0] r_mem [STORE_DEPTH];
    logic [ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lvc_acc_unit.sv @@
// ----------------------------------------------------------------------------
// lvc_acc_unit
// Per-center squared distance accumulators in a RAM, with a read-modify-write
// stage and a running nearest-center search over one scan.
// ----------------------------------------------------------------------------
module lvc_acc_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lvc_pkg::t_acc_ctl           i_ctl,
    input  logic [lvc_pkg::ELEM_W-1:0]  i_center_byte,
    output lvc_pkg::t_acc_best          o_best
);
    import lvc_pkg::*;

    logic [ACC_W-1:0]  r_acc_mem [MAX_CENTERS];
    logic [ACC_W-1:0]  r_acc_rd;

    logic              r_s1_valid;
    logic [CIDX_W-1:0] r_s1_idx;
    logic              r_s1_zero;
    logic              r_s1_add;
    logic [ELEM_W-1:0] r_s1_elem;

    logic              r_found;
    logic [CIDX_W-1:0] r_best_idx;
    logic [ACC_W-1:0]  r_best_dist;

    logic [ACC_W-1:0]    acc_old;
    logic [ELEM_W-1:0]   diff;
    logic [2*ELEM_W-1:0] sq;
    logic [ACC_W:0]      sum;
    logic [ACC_W-1:0]    acc_new;

    // position zero means a fresh vector: old accumulator contents are stale
    always_comb begin
        acc_old = r_s1_zero ? '0 : r_acc_rd;
        diff    = (r_s1_elem >= i_center_byte) ? (r_s1_elem - i_center_byte)
                                               : (i_center_byte - r_s1_elem);
        sq      = diff * diff;
        sum     = {1'b0, acc_old} + (r_s1_add ? (ACC_W+1)'(sq) : '0);
        acc_new = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_acc_rd <= r_acc_mem[i_ctl.idx];
        end
        if (r_s1_valid) begin
            r_acc_mem[r_s1_idx] <= acc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= i_ctl.idx;
        r_s1_zero <= i_ctl.zero_acc;
        r_s1_add  <= i_ctl.add_en;
        r_s1_elem <= i_ctl.elem;
    end

    // strict less-than keeps the earliest center on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (r_s1_valid && (!r_found || acc_new < r_best_dist)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && !i_ctl.start && (!r_found || acc_new < r_best_dist)) begin
            r_best_idx  <= r_s1_idx;
            r_best_dist <= acc_new;
        end
    end

    assign o_best.idx     = r_best_idx;
    assign o_best.dist_sq = r_best_dist;

endmodule

@@ rtl/lvc_checker.sv @@
// ----------------------------------------------------------------------------
// lvc_checker
// Port-level checks for leader_vector_clustering, bound to the top level.
// ----------------------------------------------------------------------------
module lvc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_stall,
    input logic [lvc_pkg::IDX_OUT_W-1:0] i_cluster_index,
    input logic                          i_new_center,
    input logic                          i_table_full,
    input logic [lvc_pkg::DIST_W-1:0]    i_min_distance_sq,
    input logic [lvc_pkg::CNT_OUT_W-1:0] i_center_count
);
    import lvc_pkg::*;

    // stalled result transaction stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_cluster_index)
            && $stable(i_center_count) && $stable(i_min_distance_sq))
        else $error("result changed while stalled");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_new_center && i_table_full))
        else $error("new_center and table_full both set");

    // a new center is always the last one in the table
    a_new_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_new_center
            |-> i_cluster_index == IDX_OUT_W'(i_center_count - CNT_OUT_W'(1)))
        else $error("new center index does not match count");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |-> i_center_count == CNT_OUT_W'(MAX_CENTERS))
        else $error("table_full with table not full");

endmodule

bind leader_vector_clustering lvc_checker u_lvc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .i_cluster_index   (o_cluster_index),
    .i_new_center      (o_new_center),
    .i_table_full      (o_table_full),
    .i_min_distance_sq (o_min_distance_sq),
    .i_center_count    (o_center_count)
);

@@ tb/sv/lvc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lvc_tb_checker
// Watches both channels of leader_vector_clustering, keeps its own copy of
// the center table and distance sums, and compares every result with the
// oldest predicted cluster assignment.
// ----------------------------------------------------------------------------
module lvc_tb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lvc_pkg::THR_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_req_type,
    input  logic [lvc_pkg::ELEM_W-1:0]    i_element,
    input  logic                          i_last_element,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [lvc_pkg::IDX_OUT_W-1:0] i_cluster_index,
    input  logic                          i_new_center,
    input  logic                          i_table_full,
    input  logic [lvc_pkg::DIST_W-1:0]    i_min_distance_sq,
    input  logic [lvc_pkg::CNT_OUT_W-1:0] i_center_count,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import lvc_pkg::*;

    localparam longint ACC_SAT = (longint'(1) << ACC_W) - 1;

    typedef struct {
        logic [IDX_OUT_W-1:0] idx;
        logic                 new_c;
        logic                 full;
        logic [DIST_W-1:0]    dist_sq;
        logic [CNT_OUT_W-1:0] count;
    } t_assignment;

    logic [ELEM_W-1:0] center_mem [MAX_CENTERS][VEC_LEN];
    logic [ACC_W-1:0]  dist_acc [MAX_CENTERS];
    int                n_centers = 0;
    int                vec_pos   = 0;
    logic [THR_W-1:0]  thr_sq    = THR_RESET;
    t_assignment       expected_assignments [$];
    int                fails     = 0;
    int                checked   = 0;
    int                pending   = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;

    task automatic restart_vector();
        for (int j = 0; j < MAX_CENTERS; j++)
            dist_acc[j] = '0;
        vec_pos = 0;
    endtask

    // one accepted transaction on the input side
    task automatic predict_assignment(input logic req, input logic [ELEM_W-1:0] elem,
                                      input logic last);
        int               best;
        logic [ACC_W-1:0] best_d;
        bit               found;
        int               diff;
        longint           sum;
        t_assignment      a;
        if (req == REQ_CLEAR) begin
            restart_vector();
            n_centers = 0;
            return;
        end
        // positions past the vector length are dropped
        if (vec_pos < VEC_LEN) begin
            for (int j = 0; j < n_centers; j++) begin
                diff = int'(elem) - int'(center_mem[j][vec_pos]);
                sum  = longint'(dist_acc[j]) + longint'(diff * diff);
                dist_acc[j] = (sum > ACC_SAT) ? ACC_W'(ACC_SAT) : ACC_W'(sum);
            end
            // element lands in the next free slot whether or not it becomes a center
            if (n_centers < MAX_CENTERS)
                center_mem[n_centers][vec_pos] = elem;
            vec_pos++;
        end
        if (!last)
            return;
        found  = 1'b0;
        best   = 0;
        best_d = '0;
        for (int j = 0; j < n_centers; j++) begin
            if (!found || dist_acc[j] < best_d) begin
                found  = 1'b1;
                best   = j;
                best_d = dist_acc[j];
            end
        end
        a.new_c = 1'b0;
        a.full  = 1'b0;
        if (found && best_d < thr_sq) begin
            a.idx = IDX_OUT_W'(best);
        end else if (n_centers < MAX_CENTERS) begin
            a.idx   = IDX_OUT_W'(n_centers);
            a.new_c = 1'b1;
            n_centers++;
        end else begin
            a.idx  = IDX_OUT_W'(best);
            a.full = 1'b1;
        end
        a.dist_sq = (!found || best_d > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(best_d);
        a.count   = CNT_OUT_W'(n_centers);
        expected_assignments.insert(expected_assignments.size(), a);
        restart_vector();
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_assignment want;
        if (!i_rst_n) begin
            restart_vector();
            n_centers = 0;
            thr_sq    = THR_RESET;
            expected_assignments.delete();
        end else begin
            if (i_cfg_we)
                thr_sq = i_cfg_wdata;
            // output first: it always belongs to an older vector
            if (i_out_valid && !i_out_stall) begin
                if (expected_assignments.size() == 0) begin
                    fails++;
                    $display("%0t: result with no vector outstanding, index %0d", $time,
                             i_cluster_index);
                end else begin
                    want = expected_assignments.pop_front();
                    checked++;
                    compare_field("cluster_index", want.idx, i_cluster_index);
                    compare_field("new_center", want.new_c, i_new_center);
                    compare_field("table_full", want.full, i_table_full);
                    compare_field("min_distance_sq", want.dist_sq, i_min_distance_sq);
                    compare_field("center_count", want.count, i_center_count);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_assignment(i_req_type, i_element, i_last_element);
        end
        pending = expected_assignments.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for leader_vector_clustering: directed vectors for the
// overlong, farthest, tie and full-table cases, then random vectors and
// clears over several thresholds, mostly with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import lvc_pkg::*;

    localparam logic [THR_W-1:0] THR_MAX      = '1;
    localparam int               FILL_RANDOM  = -1;
    localparam int               PRIME_LEN    = 4;  // every slot is written this deep
    localparam int               SETTLE       = MAX_CENTERS + 8;
    localparam int               HOLD_CYCLES  = 600;
    localparam int               CYCLE_LIMIT  = 1_000_000;
    localparam int               RANDOM_ITEMS = 500;
    localparam int               PHASES       = 6;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 cfg_we          = 1'b0;
    logic [THR_W-1:0]     cfg_wdata       = '0;
    logic                 in_valid        = 1'b0;
    logic                 in_stall;
    logic                 req_type        = REQ_FEATURE;
    logic [ELEM_W-1:0]    element         = '0;
    logic                 last_element    = 1'b0;
    logic                 out_valid;
    logic                 out_stall       = 1'b0;
    logic [IDX_OUT_W-1:0] cluster_index;
    logic                 new_center;
    logic                 table_full;
    logic [DIST_W-1:0]    min_distance_sq;
    logic [CNT_OUT_W-1:0] center_count;

    int fail_count;
    int pending;
    int checked;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int elems         = 0;
    int clears        = 0;
    int vectors       = 0;
    int settings      = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    leader_vector_clustering dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_req_type        (req_type),
        .i_element         (element),
        .i_last_element    (last_element),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_cluster_index   (cluster_index),
        .o_new_center      (new_center),
        .o_table_full      (table_full),
        .o_min_distance_sq (min_distance_sq),
        .o_center_count    (center_count)
    );

    lvc_tb_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_req_type        (req_type),
        .i_element         (element),
        .i_last_element    (last_element),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_cluster_index   (cluster_index),
        .i_new_center      (new_center),
        .i_table_full      (table_full),
        .i_min_distance_sq (min_distance_sq),
        .i_center_count    (center_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
            out_stall   <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // returns at the edge where the transaction is taken
    task automatic send_item(input logic req, input logic [ELEM_W-1:0] elem, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        element      <= elem;
        last_element <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (req == REQ_CLEAR)
            clears++;
        else
            elems++;
    endtask

    task automatic send_clear();
        send_item(REQ_CLEAR, ELEM_W'($urandom), 1'($urandom));
    endtask

    // half the elements come from a coarse grid so that matches and ties occur
    function automatic logic [ELEM_W-1:0] pick_element();
        if ($urandom_range(1) == 1)
            return ELEM_W'($urandom_range(3) * 85);
        return ELEM_W'($urandom);
    endfunction

    task automatic send_vector(input int len, input int fill);
        for (int k = 0; k < len; k++)
            send_item(REQ_FEATURE, (fill == FILL_RANDOM) ? pick_element() : ELEM_W'(fill),
                      k == len - 1);
        vectors++;
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    initial begin : stimulus
        int               target;
        logic [THR_W-1:0] thr;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 22;
        rx_idle_pct = 69;

        // reset threshold: empty table, then a close match
        send_vector(1, 0);
        send_vector(1, 255);
        send_clear();
        // overlong vector on an empty table, then the farthest possible vector
        send_vector(VEC_LEN + 6, 0);
        send_vector(VEC_LEN, 255);

        // zero threshold: every vector is new until the table is full
        settle_idle();
        write_threshold('0);
        send_vector(PRIME_LEN, 10);
        send_vector(PRIME_LEN, 10);
        repeat (MAX_CENTERS - 4) send_vector(PRIME_LEN, FILL_RANDOM);
        send_vector(PRIME_LEN, 10);  // full table, centers 2 and 3 tie at zero
        send_vector(PRIME_LEN, FILL_RANDOM);

        settle_idle();
        write_threshold(THR_MAX);
        send_vector(PRIME_LEN, 10);
        send_vector(3, FILL_RANDOM);
        send_item(REQ_FEATURE, 8'd1, 1'b0);
        send_item(REQ_FEATURE, 8'd254, 1'b0);
        send_clear();                // aborts a vector midway
        send_vector(2, FILL_RANDOM);

        for (int p = 0; p < PHASES; p++) begin
            settle_idle();
            case (p / 2)
                0: begin
                    tx_idle_pct = 22;
                    rx_idle_pct = 69;
                end
                1: begin
                    tx_idle_pct = 69;
                    rx_idle_pct = 22;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (p)
                0:       thr = THR_W'($urandom_range(60000));
                1:       thr = '0;
                2:       thr = THR_W'($urandom_range(300000));
                3:       thr = THR_MAX;
                4:       thr = THR_W'($urandom_range(20000));
                default: thr = THR_RESET;
            endcase
            write_threshold(thr);
            if (p == 2) begin
                // receiver holds off while short vectors keep coming
                hold_requests++;
                repeat (24) send_vector(1, FILL_RANDOM);
            end
            target = elems + clears + RANDOM_ITEMS / PHASES;
            while (elems + clears < target) begin
                if ($urandom_range(99) < 8) begin
                    send_clear();
                    // only an empty table allows a vector longer than the primed depth
                    if ($urandom_range(99) < 30)
                        send_vector($urandom_range(5, 40), FILL_RANDOM);
                end else if ($urandom_range(99) < 3) begin
                    repeat ($urandom_range(1, 3)) send_item(REQ_FEATURE, pick_element(), 1'b0);
                    send_clear();
                end else begin
                    send_vector($urandom_range(1, PRIME_LEN), FILL_RANDOM);
                end
            end
        end

        settle_idle();
        $display("Run covered %0d vectors (%0d elements, %0d clears) over %0d threshold settings",
                 vectors, elems, clears, settings + 1);
        $display("with stalls on both sides; %0d results compared, %0d outstanding.",
                 checked, pending);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lvc_pkg.sv
rtl/lvc_center_mem.sv
rtl/lvc_acc_unit.sv
rtl/leader_vector_clustering.sv
rtl/lvc_checker.sv
tb/sv/lvc_checker.sv
tb/sv/testbench.sv
